// ----- rtl/ctp_pkg.sv -----
// Shared types and character constants for the color text parser.
package ctp_pkg;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_HEX    = 3'd1,
        MODE_PREFIX = 3'd2,
        MODE_LEAD   = 3'd3,
        MODE_BODY   = 3'd4,
        MODE_TAIL   = 3'd5,
        MODE_FAIL   = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         count;
        logic [31:0]        acc;
        logic [1:0]         comp;
        logic [8:0]         dec;
        logic               minus;
        logic               digit;
        logic [2:0][7:0]    rgb;
    } parse_state_t;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0][7:0] PREFIX_TEXT = {8'h28, 8'h62, 8'h67, 8'h72};

    localparam logic [8:0]  DEC_SAT    = 9'd256;
    localparam logic [8:0]  DEC_MAX    = 9'd255;
    localparam logic [7:0]  ALPHA_FULL = 8'hFF;

endpackage

// ----- rtl/ctp_req_if.sv -----
// Request channel: one character of color text per transfer.
interface ctp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

// ----- rtl/ctp_rsp_if.sv -----
// Response channel: parse verdict and ARGB color.
interface ctp_rsp_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] argb;

    modport source (output valid, output valid_res, output argb, input ready);
    modport sink   (input valid, input valid_res, input argb, output ready);
endinterface

// ----- rtl/ctp_parse.sv -----
// Next-state logic of the parser for one character.
module ctp_parse
    import ctp_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   char_code,
    output parse_state_t st_next
);

    logic        is_dec;
    logic        is_blank;
    logic        is_hex;
    logic [3:0]  nib;
    logic [3:0]  dec_digit;
    logic [11:0] dec_wide;
    logic [1:0]  wr_idx;

    always_comb
    begin
        is_dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_blank  = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
        dec_digit = 4'(char_code - CH_ZERO);
        is_hex    = 1'b1;
        nib       = dec_digit;
        if (is_dec)
        begin
            nib = dec_digit;
        end
        else if (char_code >= 8'h61 && char_code <= 8'h66)
        begin
            nib = 4'(char_code - 8'h57);
        end
        else if (char_code >= 8'h41 && char_code <= 8'h46)
        begin
            nib = 4'(char_code - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
        dec_wide = ({3'b000, st.dec} << 3) + ({3'b000, st.dec} << 1) + {8'h00, dec_digit};
        wr_idx   = (st.comp == 2'd3) ? 2'd0 : st.comp;
    end

    always_comb
    begin
        st_next = st;
        case (st.mode)
            MODE_START:
            begin
                if (char_code == CH_HASH)
                begin
                    st_next.mode  = MODE_HEX;
                    st_next.count = 4'd0;
                    st_next.acc   = 32'd0;
                end
                else if (char_code == PREFIX_TEXT[0])
                begin
                    st_next.mode  = MODE_PREFIX;
                    st_next.count = 4'd1;
                end
                else
                begin
                    st_next.mode = MODE_FAIL;
                end
            end
            MODE_HEX:
            begin
                if (!is_hex)
                begin
                    st_next.mode = MODE_FAIL;
                end
                else
                begin
                    if (st.count < 4'd8)
                    begin
                        st_next.acc = {st.acc[27:0], nib};
                    end
                    if (st.count < 4'd9)
                    begin
                        st_next.count = st.count + 4'd1;
                    end
                end
            end
            MODE_PREFIX:
            begin
                if (st.count < 4'd4 && char_code == PREFIX_TEXT[st.count[1:0]])
                begin
                    st_next.count = st.count + 4'd1;
                    if (st.count == 4'd3)
                    begin
                        st_next.mode  = MODE_LEAD;
                        st_next.comp  = 2'd0;
                        st_next.dec   = 9'd0;
                        st_next.minus = 1'b0;
                        st_next.digit = 1'b0;
                    end
                end
                else
                begin
                    st_next.mode = MODE_FAIL;
                end
            end
            MODE_LEAD:
            begin
                if (is_blank)
                begin
                    st_next.mode = MODE_LEAD;
                end
                else if (char_code == CH_PLUS || char_code == CH_MINUS)
                begin
                    st_next.minus = (char_code == CH_MINUS);
                    st_next.mode  = MODE_BODY;
                end
                else if (is_dec)
                begin
                    st_next.dec   = {5'd0, dec_digit};
                    st_next.digit = 1'b1;
                    st_next.mode  = MODE_BODY;
                end
                else
                begin
                    st_next.mode = MODE_FAIL;
                end
            end
            MODE_BODY:
            begin
                if (is_dec)
                begin
                    // saturate so long digit runs stay out of range
                    st_next.dec   = (dec_wide > {3'b000, DEC_SAT}) ? DEC_SAT : dec_wide[8:0];
                    st_next.digit = 1'b1;
                end
                else if (!st.digit)
                begin
                    st_next.mode = MODE_FAIL;
                end
                else if (st.dec > DEC_MAX || (st.minus && st.dec != 9'd0))
                begin
                    st_next.mode = MODE_FAIL;
                end
                else
                begin
                    st_next.rgb[wr_idx] = st.dec[7:0];
                    if (st.comp >= 2'd2)
                    begin
                        st_next.mode = MODE_TAIL;
                    end
                    else if (char_code == CH_COMMA)
                    begin
                        st_next.comp  = st.comp + 2'd1;
                        st_next.dec   = 9'd0;
                        st_next.minus = 1'b0;
                        st_next.digit = 1'b0;
                        st_next.mode  = MODE_LEAD;
                    end
                    else
                    begin
                        st_next.mode = MODE_FAIL;
                    end
                end
            end
            MODE_TAIL:
            begin
                st_next.mode = MODE_TAIL;
            end
            default:
            begin
                st_next.mode = MODE_FAIL;
            end
        endcase
    end

endmodule

// ----- rtl/ctp_format.sv -----
// Verdict and ARGB assembly from the state after the last character.
module ctp_format
    import ctp_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   char_code,
    output logic         valid_res,
    output logic [31:0]  argb
);

    always_comb
    begin
        valid_res = 1'b0;
        argb      = 32'd0;
        if (st.mode == MODE_HEX)
        begin
            if (st.count == 4'd3)
            begin
                // times 17 duplicates the nibble
                valid_res = 1'b1;
                argb = {ALPHA_FULL, st.acc[11:8], st.acc[11:8], st.acc[7:4], st.acc[7:4],
                        st.acc[3:0], st.acc[3:0]};
            end
            else if (st.count == 4'd6)
            begin
                valid_res = 1'b1;
                argb      = {ALPHA_FULL, st.acc[23:0]};
            end
            else if (st.count == 4'd8)
            begin
                valid_res = 1'b1;
                argb      = st.acc;
            end
        end
        else if (st.mode == MODE_TAIL && char_code == CH_RPAREN)
        begin
            valid_res = 1'b1;
            argb      = {ALPHA_FULL, st.rgb[0], st.rgb[1], st.rgb[2]};
        end
    end

endmodule

// ----- rtl/color_text_parser.sv -----
// The result of a final character is registered into the result register at the edge that accepts it.
// Throughput: one character per cycle; the next request is taken while a result waits,
//   stalling only when the result register is full and not being taken.
// Each character updates the parse state in one pass of logic.
// Reset: asynchronous active-low; parse state returns to expecting the first
//   character and the result register empties.
module color_text_parser
    import ctp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ctp_req_if.sink    req,
    ctp_rsp_if.source  rsp
);

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t st_step;
    logic         out_valid_reg;
    logic         valid_res_reg;
    logic [31:0]  argb_reg;
    logic         fmt_valid;
    logic [31:0]  fmt_argb;
    logic         in_acc;

    localparam parse_state_t ST_RESET = '{mode: MODE_START, count: 4'd0, acc: 32'd0,
                                          comp: 2'd0, dec: 9'd0, minus: 1'b0,
                                          digit: 1'b0, rgb: '0};

    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_acc    = req.valid && req.ready;

    ctp_parse u_parse (
        .st        (st_reg),
        .char_code (req.char_code),
        .st_next   (st_step)
    );

    ctp_format u_format (
        .st        (st_step),
        .char_code (req.char_code),
        .valid_res (fmt_valid),
        .argb      (fmt_argb)
    );

    always_comb
    begin
        st_next = st_reg;
        if (in_acc)
        begin
            st_next = req.final_char ? ST_RESET : st_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (in_acc && req.final_char)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result payload until a new final character lands
    always_ff @(posedge clk)
    begin
        if (in_acc && req.final_char)
        begin
            valid_res_reg <= fmt_valid;
            argb_reg      <= fmt_argb;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.valid_res = valid_res_reg;
    assign rsp.argb      = argb_reg;

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_acc && req.final_char))
        else $error("result appeared without a final character");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req.final_char) |=> (st_reg.mode == MODE_START))
        else $error("parse state not cleared after final character");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |-> (argb_reg == 32'd0))
        else $error("rejected string carries nonzero color");

endmodule

// ----- sim/tb_color_text_parser.sv -----
// Self-checking testbench for the color text parser: hex, rgb() and stray-byte strings against a shadow parser.
`timescale 1ns / 1ps

module tb_color_text_parser;
    import ctp_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] argb;
    } color_result_t;

    logic clk;
    logic rst_n;

    ctp_req_if req_ch ();
    ctp_rsp_if rsp_ch ();

    color_text_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    parse_state_t  shadow;
    color_result_t pending_colors[$];
    logic [7:0]    text_buf[$];
    int            error_count = 0;
    int            chars_sent = 0;
    int            burst_left = 0;
    int            cycle_count = 0;
    bit            hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out with %0d results outstanding", $time, pending_colors.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int nibble_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Advance the shadow parser by one character; queue the color on the last one.
    task automatic track_char(input logic [7:0] c, input logic fin);
        int            nib;
        int            acc10;
        color_result_t res;
        case (shadow.mode)
            MODE_START:
            begin
                if (c == CH_HASH)
                begin
                    shadow.mode  = MODE_HEX;
                    shadow.count = '0;
                    shadow.acc   = '0;
                end
                else if (c == PREFIX_TEXT[0])
                begin
                    shadow.mode  = MODE_PREFIX;
                    shadow.count = 4'd1;
                end
                else
                    shadow.mode = MODE_FAIL;
            end
            MODE_HEX:
            begin
                nib = nibble_value(c);
                if (nib < 0)
                    shadow.mode = MODE_FAIL;
                else
                begin
                    if (shadow.count < 4'd8)
                        shadow.acc = {shadow.acc[27:0], 4'(nib)};
                    if (shadow.count < 4'd9)
                        shadow.count = shadow.count + 4'd1;
                end
            end
            MODE_PREFIX:
            begin
                if (shadow.count < 4'd4 && c == PREFIX_TEXT[shadow.count[1:0]])
                begin
                    shadow.count = shadow.count + 4'd1;
                    if (shadow.count == 4'd4)
                    begin
                        shadow.mode  = MODE_LEAD;
                        shadow.comp  = '0;
                        shadow.dec   = '0;
                        shadow.minus = 1'b0;
                        shadow.digit = 1'b0;
                    end
                end
                else
                    shadow.mode = MODE_FAIL;
            end
            MODE_LEAD:
            begin
                if (is_blank(c))
                    ;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    shadow.minus = (c == CH_MINUS);
                    shadow.mode  = MODE_BODY;
                end
                else if (is_digit(c))
                begin
                    shadow.dec   = 9'(c - CH_ZERO);
                    shadow.digit = 1'b1;
                    shadow.mode  = MODE_BODY;
                end
                else
                    shadow.mode = MODE_FAIL;
            end
            MODE_BODY:
            begin
                if (is_digit(c))
                begin
                    acc10 = int'(shadow.dec) * 10 + int'(c - CH_ZERO);
                    if (acc10 > int'(DEC_SAT))
                        acc10 = int'(DEC_SAT);
                    shadow.dec   = 9'(acc10);
                    shadow.digit = 1'b1;
                end
                else if (!shadow.digit)
                    shadow.mode = MODE_FAIL;
                else if (shadow.dec > DEC_MAX || (shadow.minus && shadow.dec != '0))
                    shadow.mode = MODE_FAIL;
                else
                begin
                    if (shadow.comp < 2'd3)
                        shadow.rgb[shadow.comp] = shadow.dec[7:0];
                    else
                        shadow.rgb[0] = shadow.dec[7:0];
                    if (shadow.comp >= 2'd2)
                        shadow.mode = MODE_TAIL;
                    else if (c == CH_COMMA)
                    begin
                        shadow.comp  = shadow.comp + 2'd1;
                        shadow.dec   = '0;
                        shadow.minus = 1'b0;
                        shadow.digit = 1'b0;
                        shadow.mode  = MODE_LEAD;
                    end
                    else
                        shadow.mode = MODE_FAIL;
                end
            end
            MODE_TAIL:
                ;
            default:
                shadow.mode = MODE_FAIL;
        endcase

        if (fin)
        begin
            res = '0;
            if (shadow.mode == MODE_HEX)
            begin
                if (shadow.count == 4'd3)
                begin
                    res.valid_res = 1'b1;
                    res.argb = {ALPHA_FULL, shadow.acc[11:8], shadow.acc[11:8],
                                shadow.acc[7:4], shadow.acc[7:4],
                                shadow.acc[3:0], shadow.acc[3:0]};
                end
                else if (shadow.count == 4'd6)
                begin
                    res.valid_res = 1'b1;
                    res.argb = {ALPHA_FULL, shadow.acc[23:0]};
                end
                else if (shadow.count == 4'd8)
                begin
                    res.valid_res = 1'b1;
                    res.argb = shadow.acc;
                end
            end
            else if (shadow.mode == MODE_TAIL && c == CH_RPAREN)
            begin
                res.valid_res = 1'b1;
                res.argb = {ALPHA_FULL, shadow.rgb[0], shadow.rgb[1], shadow.rgb[2]};
            end
            pending_colors.insert(pending_colors.size(), res);
            shadow = '0;
            shadow.mode = MODE_START;
        end
    endtask

    // Offer one request, in bursts with random gaps, and hold it until taken.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.char_code  <= c;
        req_ch.final_char <= fin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        chars_sent++;
        track_char(c, fin);
    endtask

    // Send the buffered string, flagging its last character; sometimes cut it short.
    task automatic send_text();
        int cut;
        if (text_buf.size() > 1 && $urandom_range(0, 19) == 0)
        begin
            cut = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > cut)
                void'(text_buf.pop_back());
        end
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        foreach (s[i])
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_colors.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return CH_ZERO + 8'(v);
        if (v < 16)
            return "a" + 8'(v - 10);
        return "A" + 8'(v - 16);
    endfunction

    function automatic logic [7:0] rand_blank();
        int v;
        v = $urandom_range(0, 5);
        return (v == 0) ? CH_SPACE : CH_TAB + 8'(v - 1);
    endfunction

    task automatic build_hex();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            n = 3;
        else if (pick < 5)
            n = 6;
        else if (pick < 7)
            n = 8;
        else
            n = $urandom_range(0, 11);
        text_buf.insert(text_buf.size(), CH_HASH);
        repeat (n) text_buf.insert(text_buf.size(), rand_hex_char());
        if ($urandom_range(0, 9) == 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic build_number();
        int    pick;
        int    v;
        string s;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_buf.insert(text_buf.size(), rand_blank());
        pick = $urandom_range(0, 15);
        if (pick == 0)
            text_buf.insert(text_buf.size(), CH_PLUS);
        else if (pick == 1)
            text_buf.insert(text_buf.size(), CH_MINUS);
        pick = $urandom_range(0, 15);
        if (pick == 14)
            return;
        if (pick < 10)
            v = $urandom_range(0, 255);
        else if (pick == 10)
            v = 0;
        else if (pick == 11)
            v = 255;
        else if (pick == 12)
            v = $urandom_range(256, 999);
        else
            v = $urandom_range(0, 99999);
        if (pick == 15)
            repeat ($urandom_range(1, 4)) text_buf.insert(text_buf.size(), CH_ZERO);
        s = $sformatf("%0d", v);
        foreach (s[i])
            text_buf.insert(text_buf.size(), s[i]);
    endtask

    task automatic build_rgb();
        for (int k = 0; k < 4; k++)
            text_buf.insert(text_buf.size(), PREFIX_TEXT[k]);
        if ($urandom_range(0, 15) == 0)
            text_buf[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 3; k++)
        begin
            build_number();
            if (k < 2)
                text_buf.insert(text_buf.size(), ($urandom_range(0, 19) == 0) ?
                                8'($urandom_range(0, 255)) : CH_COMMA);
        end
        // junk after the third number is allowed; only the closing byte counts
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        text_buf.insert(text_buf.size(), ($urandom_range(0, 14) == 0) ?
                        8'($urandom_range(0, 255)) : CH_RPAREN);
    endtask

    task automatic build_stray();
        int pick;
        pick = $urandom_range(0, 2);
        text_buf.insert(text_buf.size(), (pick == 0) ? CH_HASH :
                        (pick == 1) ? PREFIX_TEXT[0] : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 5))
            text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        send_string("#0aF");
        send_string("rgb(-0,+255,\t7)");
        send_string("#");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_hex_colors();
        while (chars_sent < 400)
        begin
            build_hex();
            send_text();
        end
    endtask

    task automatic test_rgb_colors();
        while (chars_sent < 1000)
        begin
            build_rgb();
            send_text();
        end
    endtask

    task automatic test_stray_bytes();
        while (chars_sent < 1150)
        begin
            build_stray();
            send_text();
        end
    endtask

    // Block the response side for a long stretch while requests keep coming.
    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (40)
            send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_idle_drain();
        wait_idle();
    endtask

    task automatic test_mixed_traffic();
        int pick;
        while (chars_sent < 1350)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                build_rgb();
            else if (pick < 7)
                build_hex();
            else
                build_stray();
            send_text();
        end
    endtask

    // Response side: take results on a shifting stall pattern and check each one.
    initial
    begin : color_checker
        int            rx_cycle;
        int            stall_style;
        int            hold_left;
        color_result_t exp_color;
        rx_cycle    = 0;
        stall_style = 0;
        hold_left   = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_colors.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got valid_res %b argb %h",
                             $time, rsp_ch.valid_res, rsp_ch.argb);
                end
                else
                begin
                    exp_color = pending_colors.pop_front();
                    if (rsp_ch.valid_res !== exp_color.valid_res)
                    begin
                        error_count++;
                        $display("%0t: valid_res mismatch, expected %b, got %b",
                                 $time, exp_color.valid_res, rsp_ch.valid_res);
                    end
                    if (rsp_ch.argb !== exp_color.argb)
                    begin
                        error_count++;
                        $display("%0t: argb mismatch, expected %h, got %h",
                                 $time, exp_color.argb, rsp_ch.argb);
                    end
                end
            end
            if (rx_cycle % 64 == 0)
                stall_style = $urandom_range(0, 3);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_style)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.char_code  <= '0;
        req_ch.final_char <= 1'b0;
        shadow = '0;
        shadow.mode = MODE_START;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_hex_colors();
        test_idle_drain();
        test_rgb_colors();
        test_output_stall();
        test_stray_bytes();
        test_mixed_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_colors.size());
        end
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ctp_pkg.sv
rtl/ctp_req_if.sv
rtl/ctp_rsp_if.sv
rtl/ctp_parse.sv
rtl/ctp_format.sv
rtl/color_text_parser.sv
sim/tb_color_text_parser.sv
